// ===== design/rau_pkg.sv =====
package rau_pkg;

  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int RES_NUM_WIDTH = 32;
  localparam int RES_DEN_WIDTH = 31;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic form;
    logic gcd_start;
    logic div_start;
    logic finish;
  } ctrl_t;

  typedef struct packed {
    logic gcd_done;
    logic div_done;
    logic zero_den;
    logic zero_num;
  } stat_t;

endpackage

// ===== design/rau_datapath.sv =====
module rau_datapath #(
  parameter int OperandWidth = rau_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  rau_pkg::ctrl_t                        ctrl,
  output rau_pkg::stat_t                        stat,
  input  logic [1:0]                            cmd,
  input  logic signed [OperandWidth-1:0]        a_num,
  input  logic [OperandWidth-2:0]               a_den,
  input  logic signed [OperandWidth-1:0]        b_num,
  input  logic [OperandWidth-2:0]               b_den,
  output logic signed [rau_pkg::RES_NUM_WIDTH-1:0] res_num,
  output logic [rau_pkg::RES_DEN_WIDTH-1:0]     res_den,
  output logic                                  less,
  output logic                                  equal,
  output logic                                  error
);

  localparam int PW = 2 * OperandWidth;
  localparam int MW = PW + 1;
  localparam int CW = $clog2(MW + 1);

  logic [1:0] op;
  logic signed [OperandWidth-1:0] an, bn;
  logic [OperandWidth-2:0] ad, bd;
  logic signed [PW-1:0] left, right, prod_n, prod_d, dalt;
  logic [MW-1:0] mn, md, gx, gy, g;
  logic [CW-1:0] gk;
  logic neg;
  logic [MW-1:0] dq, dr, dd;
  logic [CW-1:0] dcnt;
  logic dsel, dbusy, gbusy;
  logic signed [MW:0] n_full, d_full;
  logic [MW:0] rsub;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      op <= cmd;
      an <= a_num;
      ad <= a_den;
      bn <= b_num;
      bd <= b_den;
    end
    if (ctrl.mul) begin
      left <= PW'(an * $signed({1'b0, bd}));
      right <= PW'(bn * $signed({1'b0, ad}));
      prod_n <= PW'(an * bn);
      prod_d <= PW'($signed({1'b0, ad}) * $signed({1'b0, bd}));
      dalt <= PW'($signed({1'b0, ad}) * bn);
    end
  end

  always_comb begin
    case (rau_pkg::cmd_t'(op))
      rau_pkg::CMD_ADD: n_full = (MW+1)'(left) + (MW+1)'(right);
      rau_pkg::CMD_SUB: n_full = (MW+1)'(left) - (MW+1)'(right);
      rau_pkg::CMD_MUL: n_full = (MW+1)'(prod_n);
      default:          n_full = (MW+1)'(left);
    endcase
    if (rau_pkg::cmd_t'(op) == rau_pkg::CMD_DIV) d_full = (MW+1)'(dalt);
    else d_full = (MW+1)'(prod_d);
  end

  // form magnitudes, then binary gcd: common twos counted in gk, one shift or
  // subtract-and-shift a cycle; then restoring division of each magnitude by the gcd
  always_ff @(posedge clk) begin
    if (rst) begin
      gbusy <= 1'b0;
      dbusy <= 1'b0;
    end else begin
      if (ctrl.form) begin
        mn <= n_full[MW] ? MW'(-n_full) : MW'(n_full);
        md <= d_full[MW] ? MW'(-d_full) : MW'(d_full);
        neg <= n_full[MW] ^ d_full[MW];
        less <= left < right;
        equal <= left == right;
      end
      if (ctrl.gcd_start) begin
        gx <= mn;
        gy <= md;
        gk <= '0;
        gbusy <= 1'b1;
      end else if (gbusy) begin
        if (gx == '0 || gy == '0) begin
          g <= (gx | gy) << gk;
          gbusy <= 1'b0;
        end else if (!gx[0] && !gy[0]) begin
          gx <= gx >> 1;
          gy <= gy >> 1;
          gk <= gk + 1'b1;
        end else if (!gx[0]) begin
          gx <= gx >> 1;
        end else if (!gy[0]) begin
          gy <= gy >> 1;
        end else if (gx >= gy) begin
          gx <= (gx - gy) >> 1;
        end else begin
          gy <= (gy - gx) >> 1;
        end
      end
      if (ctrl.div_start) begin
        dq <= dsel ? md : mn;
        dr <= '0;
        dd <= g;
        dcnt <= CW'(MW);
        dbusy <= 1'b1;
      end else if (dbusy) begin
        if (!rsub[MW]) dr <= rsub[MW-1:0];
        else dr <= {dr[MW-2:0], dq[MW-1]};
        dq <= {dq[MW-2:0], !rsub[MW]};
        dcnt <= dcnt - 1'b1;
        if (dcnt == CW'(1)) dbusy <= 1'b0;
      end
      if (ctrl.finish) begin
        if (!dsel) dsel <= 1'b1;
      end
      if (ctrl.gcd_start) dsel <= 1'b0;
    end
  end

  assign rsub = {1'b0, dr[MW-2:0], dq[MW-1]} - {1'b0, dd};

  // capture the numerator quotient, then the result registers
  logic [MW-1:0] qn;
  always_ff @(posedge clk) begin
    if (ctrl.finish && !dsel) qn <= dq;
    if (ctrl.finish && dsel) begin
      error <= stat.zero_den;
      if (stat.zero_den || stat.zero_num) begin
        res_num <= rau_pkg::RES_NUM_WIDTH'(0);
        res_den <= rau_pkg::RES_DEN_WIDTH'(1);
      end else begin
        res_num <= neg ? rau_pkg::RES_NUM_WIDTH'(-qn) : rau_pkg::RES_NUM_WIDTH'(qn);
        res_den <= rau_pkg::RES_DEN_WIDTH'(dq);
      end
    end
  end

  assign stat.gcd_done = !gbusy;
  assign stat.div_done = !dbusy;
  assign stat.zero_den = md == '0;
  assign stat.zero_num = mn == '0;

endmodule

// ===== design/rau_ctrl.sv =====
module rau_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output rau_pkg::ctrl_t ctrl,
  input  rau_pkg::stat_t stat
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MUL  = 9'b000000010,
    S_FORM = 9'b000000100,
    S_GCD0 = 9'b000001000,
    S_GCD  = 9'b000010000,
    S_DIVN = 9'b000100000,
    S_WN   = 9'b001000000,
    S_DIVD = 9'b010000000,
    S_WD   = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic out_valid_next;

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);

  always_comb begin
    state_next = state;
    ctrl = '0;
    out_valid_next = out_valid && out_stall;
    case (state)
      S_IDLE: if (in_valid && !in_stall) begin
        ctrl.load = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        ctrl.mul = 1'b1;
        state_next = S_FORM;
      end
      S_FORM: begin
        ctrl.form = 1'b1;
        state_next = S_GCD0;
      end
      S_GCD0: begin
        ctrl.gcd_start = 1'b1;
        state_next = S_GCD;
      end
      S_GCD: if (stat.gcd_done) begin
        if (stat.zero_den || stat.zero_num) begin
          ctrl.finish = 1'b1;
          state_next = S_WD;
        end else state_next = S_DIVN;
      end
      S_DIVN: begin
        ctrl.div_start = 1'b1;
        state_next = S_WN;
      end
      S_WN: if (stat.div_done) begin
        ctrl.finish = 1'b1;
        state_next = S_DIVD;
      end
      S_DIVD: begin
        ctrl.div_start = 1'b1;
        state_next = S_WD;
      end
      S_WD: if (stat.div_done && !(out_valid && out_stall)) begin
        ctrl.finish = 1'b1;
        out_valid_next = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTH
  a_idle_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> state == S_IDLE) else $error("accept outside idle");
  a_mul_follows: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> state == S_MUL) else $error("load not followed by mul");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $countones({ctrl.load, ctrl.mul, ctrl.form, ctrl.gcd_start, ctrl.div_start}) <= 1)
    else $error("several commands");
`endif

endmodule

// ===== design/rational_arithmetic_unit.sv =====
// channel | valid     | stall     | payload
// in      | in_valid  | in_stall  | cmd a_num a_den b_num b_den
// out     | out_valid | out_stall | res_num res_den less equal error
// one item at a time; load, multiply, form, gcd, then numerator and denominator division
// binary gcd, one shift or subtract-and-shift a cycle
// synchronous active-high reset clears controller and handshake state
// result register holds while out_stall is high; input stalls until idle and while a held result is stalled
module rational_arithmetic_unit #(
  parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic [1:0]                                cmd,
  input  logic signed [OPERAND_WIDTH-1:0]           a_num,
  input  logic [OPERAND_WIDTH-2:0]                  a_den,
  input  logic signed [OPERAND_WIDTH-1:0]           b_num,
  input  logic [OPERAND_WIDTH-2:0]                  b_den,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic signed [rau_pkg::RES_NUM_WIDTH-1:0]  res_num,
  output logic [rau_pkg::RES_DEN_WIDTH-1:0]         res_den,
  output logic                                      less,
  output logic                                      equal,
  output logic                                      error
);

  rau_pkg::ctrl_t ctrl;
  rau_pkg::stat_t stat;

  rau_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .ctrl, .stat
  );

  rau_datapath #(.OperandWidth(OPERAND_WIDTH)) u_dp (
    .clk, .rst, .ctrl, .stat, .cmd, .a_num, .a_den, .b_num, .b_den,
    .res_num, .res_den, .less, .equal, .error
  );

endmodule

// ===== test/tb.sv =====
module tb;

  typedef struct {
    rau_pkg::cmd_t cmd;
    logic signed [15:0] a_num;
    logic [14:0] a_den;
    logic signed [15:0] b_num;
    logic [14:0] b_den;
  } frac_pair_t;

  typedef struct {
    logic signed [31:0] num;
    logic [30:0] den;
    logic less;
    logic equal;
    logic error;
  } frac_res_t;

  typedef struct {
    frac_pair_t op;
    bit typed;
    frac_res_t res;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] cmd = '0;
  logic signed [15:0] a_num = '0;
  logic [14:0] a_den = 15'd1;
  logic signed [15:0] b_num = '0;
  logic [14:0] b_den = 15'd1;
  logic out_valid;
  logic out_stall = 0;
  logic signed [31:0] res_num;
  logic [30:0] res_den;
  logic less, equal, error;

  frac_res_t pending_q[$];
  int fails = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_err = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 0;
  int hold_cnt = 0;
  bit hold_done = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  rational_arithmetic_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
    .out_valid(out_valid), .out_stall(out_stall),
    .res_num(res_num), .res_den(res_den), .less(less), .equal(equal), .error(error)
  );

  function automatic frac_res_t reduce_frac(frac_pair_t p);
    longint an, ad, bn, bd, lhs, rhs, n, d;
    longint unsigned mn, md, x, y, r;
    bit neg;
    frac_res_t o;
    an = p.a_num;
    ad = longint'(p.a_den);
    bn = p.b_num;
    bd = longint'(p.b_den);
    lhs = an * bd;
    rhs = bn * ad;
    case (p.cmd)
      rau_pkg::CMD_ADD: begin n = lhs + rhs; d = ad * bd; end
      rau_pkg::CMD_SUB: begin n = lhs - rhs; d = ad * bd; end
      rau_pkg::CMD_MUL: begin n = an * bn; d = ad * bd; end
      default: begin n = lhs; d = ad * bn; end
    endcase
    o.num = 0;
    o.den = 1;
    o.error = 0;
    if (d == 0) begin
      o.error = 1;
    end else if (n != 0) begin
      mn = n < 0 ? -n : n;
      md = d < 0 ? -d : d;
      x = mn;
      y = md;
      while (y != 0) begin
        r = x % y;
        x = y;
        y = r;
      end
      neg = (n < 0) != (d < 0);
      mn = mn / x;
      md = md / x;
      o.num = neg ? -mn : mn;
      o.den = md;
    end
    o.less = lhs < rhs;
    o.equal = lhs == rhs;
    return o;
  endfunction

  // receiver: random stall plus one long hold-off
  always @(posedge clk) begin
    if (hold_req && !hold_done && hold_cnt == 0) begin
      hold_cnt <= 400;
      hold_done <= 1;
      out_stall <= 1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1;
    end else begin
      out_stall <= $urandom_range(99) < stall_pct;
    end
  end

  always @(posedge clk) begin
    frac_res_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %0d/%0d", $time, res_num, res_den);
        fails++;
      end else begin
        e = pending_q.pop_front();
        n_checked++;
        if (res_num !== e.num || res_den !== e.den || less !== e.less ||
            equal !== e.equal || error !== e.error) begin
          $display("%0t: expected %0d/%0d l%0b e%0b err%0b got %0d/%0d l%0b e%0b err%0b",
                   $time, e.num, e.den, e.less, e.equal, e.error,
                   res_num, res_den, less, equal, error);
          fails++;
        end
      end
    end
  end

  task automatic send_pair(frac_pair_t p, frac_res_t e);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    cmd <= p.cmd;
    a_num <= p.a_num;
    a_den <= p.a_den;
    b_num <= p.b_num;
    b_den <= p.b_den;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_q.push_back(e);
    n_sent++;
    if (e.error) n_err++;
  endtask

  function automatic frac_pair_t random_pair();
    frac_pair_t p;
    int k;
    p.cmd = rau_pkg::cmd_t'($urandom_range(3));
    k = $urandom_range(99);
    if (k < 50) begin
      p.a_num = $urandom_range(40) - 20;
      p.b_num = $urandom_range(40) - 20;
      p.a_den = $urandom_range(20, 1);
      p.b_den = $urandom_range(20, 1);
    end else if (k < 90) begin
      p.a_num = $urandom_range(65535);
      p.b_num = $urandom_range(65535);
      p.a_den = $urandom_range(32767, 1);
      p.b_den = $urandom_range(32767, 1);
    end else begin
      p.a_num = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      p.b_num = $urandom_range(2) == 0 ? 16'sd0 : ($urandom_range(1) ? 16'sh7fff : 16'sh8000);
      p.a_den = $urandom_range(1) ? 15'h7fff : 15'd1;
      p.b_den = $urandom_range(1) ? 15'h7fff : 15'd1;
    end
    return p;
  endfunction

  row_t rows[] = '{
    '{'{rau_pkg::CMD_ADD, 16'sd0, 15'd1, 16'sd0, 15'd1}, 1,
      '{32'sd0, 31'd1, 1'b0, 1'b1, 1'b0}},
    '{'{rau_pkg::CMD_DIV, 16'sd1, 15'd1, 16'sd0, 15'd1}, 1,
      '{32'sd0, 31'd1, 1'b0, 1'b0, 1'b1}},
    '{'{rau_pkg::CMD_DIV, -16'sd32768, 15'd1, 16'sd0, 15'd32767}, 1,
      '{32'sd0, 31'd1, 1'b1, 1'b0, 1'b1}},
    '{'{rau_pkg::CMD_MUL, -16'sd32768, 15'd1, -16'sd32768, 15'd1}, 1,
      '{32'sd1073741824, 31'd1, 1'b0, 1'b1, 1'b0}},
    '{'{rau_pkg::CMD_SUB, 16'sd32767, 15'd1, -16'sd32768, 15'd1}, 1,
      '{32'sd65535, 31'd1, 1'b0, 1'b0, 1'b0}},
    '{'{rau_pkg::CMD_ADD, 16'sd1, 15'd32767, 16'sd1, 15'd32767}, 1,
      '{32'sd2, 31'd32767, 1'b0, 1'b1, 1'b0}},
    '{'{rau_pkg::CMD_DIV, 16'sd1, 15'd2, -16'sd1, 15'd3}, 1,
      '{-32'sd3, 31'd2, 1'b0, 1'b0, 1'b0}},
    '{'{rau_pkg::CMD_SUB, 16'sd5, 15'd7, 16'sd5, 15'd7}, 1,
      '{32'sd0, 31'd1, 1'b0, 1'b1, 1'b0}},
    '{'{rau_pkg::CMD_MUL, -16'sd32768, 15'd32767, 16'sd32767, 15'd1}, 0,
      '{0, 0, 0, 0, 0}},
    '{'{rau_pkg::CMD_ADD, 16'sd32767, 15'd32767, -16'sd32768, 15'd32767}, 0,
      '{0, 0, 0, 0, 0}},
    '{'{rau_pkg::CMD_DIV, -16'sd32768, 15'd1, 16'sd1, 15'd32767}, 0,
      '{0, 0, 0, 0, 0}},
    '{'{rau_pkg::CMD_DIV, 16'sd32767, 15'd32767, -16'sd32768, 15'd1}, 0,
      '{0, 0, 0, 0, 0}},
    '{'{rau_pkg::CMD_SUB, -16'sd32768, 15'd32767, 16'sd32767, 15'd1}, 0,
      '{0, 0, 0, 0, 0}},
    '{'{rau_pkg::CMD_MUL, 16'sd6, 15'd4, -16'sd2, 15'd9}, 0, '{0, 0, 0, 0, 0}},
    '{'{rau_pkg::CMD_ADD, -16'sd3, 15'd10, 16'sd1, 15'd6}, 0, '{0, 0, 0, 0, 0}},
    '{'{rau_pkg::CMD_DIV, -16'sd4, 15'd9, -16'sd8, 15'd3}, 0, '{0, 0, 0, 0, 0}}
  };

  initial begin
    frac_pair_t p;
    repeat (2) @(posedge clk);
    rst <= 0;
    foreach (rows[i]) send_pair(rows[i].op, rows[i].typed ? rows[i].res : reduce_frac(rows[i].op));
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 51; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 51; end
        default: begin idle_pct = 37; stall_pct = 37; end
      endcase
      for (int i = 0; i < 500; i++) begin
        if (ph == 0 && i == 100) hold_req = 1;
        p = random_pair();
        send_pair(p, reduce_frac(p));
      end
    end
    in_valid <= 0;
    wait (pending_q.size() == 0);
    repeat (300) @(posedge clk);
    $display("%0d transfers in, %0d results checked, %0d divide-by-zero cases", n_sent,
             n_checked, n_err);
    $display("all four operations over extremes and random fractions, four idling mixes");
    if (fails == 0 && pending_q.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #400000000;
    $display("simulation failed");
    $finish;
  end

endmodule
